// ===== hw/rtl/dmpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dmpt_pkg;

    // Table size; a power of two, so the slot index is the low bits of the hash
    localparam int TABLE_ENTRIES = 4096;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam int HASH_W  = 64;
    localparam int MAP_W   = 64;
    localparam int TURN_W  = 6;
    localparam int VALUE_W = 2;
    localparam int COUNT_W = 32;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 6;

    // Request tdata: position_hash, mirror_hash, white, black, turn, store_value
    localparam int IN_DATA_W  = 264;
    // Response tdata: found_value, entries_used, collisions, misses, zero fill
    localparam int OUT_DATA_W = 104;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TURN_LIMIT_EN = 3'd0,
        CFG_TURN_LIMIT    = 3'd1,
        CFG_SYM_EN        = 3'd2,
        CFG_SYM_LIMIT_EN  = 3'd3,
        CFG_SYM_TURN_LIM  = 3'd4
    } cfg_addr_t;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_STORE  = 1'b1
    } op_t;

    // One table slot as held in memory
    typedef struct packed {
        logic               valid;
        logic [MAP_W-1:0]   white;
        logic [MAP_W-1:0]   black;
        logic [VALUE_W-1:0] value;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

endpackage : dmpt_pkg

`default_nettype wire

// ===== hw/rtl/dmpt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dmpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : dmpt_ram

`default_nettype wire

// ===== hw/rtl/direct_mapped_position_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake         tuser            tdata
// s_*       in   s_tvalid/tready   operation        lookup/store request
// m_*       out  m_tvalid/tready   hit              one response per request
// cfg_*     in   cfg_we            -                register index + write data
//
// The accept cycle issues the slot read; the next cycle compares the slot, writes
// it back on a store and loads the response register. With a single read/write
// port pair in the slot memory, a new request waits until the last one has left
// its compare cycle. After reset a clearing pass walks all TABLE_ENTRIES slots,
// one per cycle, with s_tready low; configuration writes are taken throughout.
// A response waiting on m_tready holds the block in its compare cycle.

module direct_mapped_position_table
    import dmpt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    // [63:0] position_hash, [127:64] mirror_hash, [191:128] white_stones,
    // [255:192] black_stones, [261:256] turn_number, [263:262] store_value
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // [0] operation
    input  wire logic                  s_tuser,

    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    // [1:0] found_value, [33:2] entries_used, [65:34] collisions,
    // [97:66] misses, [103:98] zero
    output      logic [OUT_DATA_W-1:0] m_tdata,
    // [0] hit
    output      logic                  m_tuser,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic              turn_limit_en_reg;
    logic [TURN_W-1:0] turn_limit_reg;
    logic              sym_en_reg;
    logic              sym_limit_en_reg;
    logic [TURN_W-1:0] sym_turn_lim_reg;

    // Request fields unpacked
    logic [HASH_W-1:0]  in_hash;
    logic [HASH_W-1:0]  in_mirror;
    logic [MAP_W-1:0]   in_white;
    logic [MAP_W-1:0]   in_black;
    logic [TURN_W-1:0]  in_turn;
    logic [VALUE_W-1:0] in_value;

    assign in_hash   = s_tdata[63:0];
    assign in_mirror = s_tdata[127:64];
    assign in_white  = s_tdata[191:128];
    assign in_black  = s_tdata[255:192];
    assign in_turn   = s_tdata[261:256];
    assign in_value  = s_tdata[263:262];

    // Request held through its compare cycle
    logic               op_reg;
    logic               skip_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [MAP_W-1:0]   white_reg;
    logic [MAP_W-1:0]   black_reg;
    logic [VALUE_W-1:0] value_reg;

    logic [IDX_W-1:0]   clr_cnt_reg;

    // Response and counters
    logic               m_valid_reg;
    logic               hit_reg;
    logic [VALUE_W-1:0] fval_reg;
    logic [COUNT_W-1:0] used_reg;
    logic [COUNT_W-1:0] coll_reg;
    logic [COUNT_W-1:0] miss_reg;

    // Slot memory port signals
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    slot_t            ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [SLOT_W-1:0] ram_rdata;
    slot_t            slot_rd;

    //--------------------------------------------------------------------
    // Index selection and turn limits
    //--------------------------------------------------------------------
    logic              s_accept;
    logic              in_skip;
    logic              in_sym;
    logic [HASH_W-1:0] sel_hash;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign in_skip  = turn_limit_en_reg && (in_turn > turn_limit_reg);
    assign in_sym   = sym_en_reg && (!sym_limit_en_reg || (in_turn < sym_turn_lim_reg));
    // Take the larger of the two hashes when symmetry applies
    assign sel_hash = (in_sym && (in_mirror >= in_hash)) ? in_mirror : in_hash;

    //--------------------------------------------------------------------
    // Compare cycle
    //--------------------------------------------------------------------
    logic advance;
    logic match;
    logic do_write;
    logic used_inc;
    logic coll_inc;
    logic miss_inc;
    logic               hit_next;
    logic [VALUE_W-1:0] fval_next;

    assign slot_rd  = slot_t'(ram_rdata);
    // Advance once the response register is free or drains this cycle
    assign advance  = (state_reg == ST_LOOK) && (!m_valid_reg || m_tready);
    assign match    = slot_rd.valid && (slot_rd.white == white_reg)
                      && (slot_rd.black == black_reg);
    assign do_write = advance && !skip_reg && (op_reg == OP_STORE);
    assign used_inc = do_write && !slot_rd.valid;
    assign coll_inc = do_write && slot_rd.valid;
    assign miss_inc = advance && !skip_reg && (op_reg == OP_LOOKUP) && !match;

    always_comb
    begin
        hit_next  = 1'b0;
        fval_next = '0;
        if (op_reg == OP_STORE)
        begin
            fval_next = value_reg;
        end
        else if (!skip_reg && match)
        begin
            hit_next  = 1'b1;
            fval_next = slot_rd.value;
        end
    end

    //--------------------------------------------------------------------
    // Slot memory: clearing pass writes, stores write back
    //--------------------------------------------------------------------
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
        end
        else if (do_write)
        begin
            ram_we          = 1'b1;
            ram_wdata.valid = 1'b1;
            ram_wdata.white = white_reg;
            ram_wdata.black = black_reg;
            ram_wdata.value = value_reg;
        end
    end

    // Skipped requests need no read, but issuing it is harmless
    assign ram_re    = s_accept;
    assign ram_raddr = sel_hash[IDX_W-1:0];

    dmpt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    //--------------------------------------------------------------------
    // Configuration writes; unknown indexes are dropped
    //--------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_limit_en_reg <= 1'b0;
            turn_limit_reg    <= '1;
            sym_en_reg        <= 1'b1;
            sym_limit_en_reg  <= 1'b0;
            sym_turn_lim_reg  <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_TURN_LIMIT_EN: turn_limit_en_reg <= cfg_wdata[0];
                CFG_TURN_LIMIT:    turn_limit_reg    <= cfg_wdata;
                CFG_SYM_EN:        sym_en_reg        <= cfg_wdata[0];
                CFG_SYM_LIMIT_EN:  sym_limit_en_reg  <= cfg_wdata[0];
                CFG_SYM_TURN_LIM:  sym_turn_lim_reg  <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    //--------------------------------------------------------------------
    // Request payload capture
    //--------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            idx_reg   <= sel_hash[IDX_W-1:0];
            white_reg <= in_white;
            black_reg <= in_black;
            value_reg <= in_value;
        end
    end

    //--------------------------------------------------------------------
    // Sequencer, response register and counters
    //--------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            op_reg      <= OP_LOOKUP;
            skip_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            hit_reg     <= 1'b0;
            fval_reg    <= '0;
            used_reg    <= '0;
            coll_reg    <= '0;
            miss_reg    <= '0;
        end
        else
        begin
            // Drop the response once taken, unless a new one loads this cycle
            if (m_valid_reg && m_tready && !advance)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == IDX_W'(TABLE_ENTRIES - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        op_reg    <= s_tuser;
                        skip_reg  <= in_skip;
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK:
                begin
                    if (advance)
                    begin
                        m_valid_reg <= 1'b1;
                        hit_reg     <= hit_next;
                        fval_reg    <= fval_next;
                        state_reg   <= ST_IDLE;
                        if (used_inc && (used_reg != '1))
                        begin
                            used_reg <= used_reg + 1'b1;
                        end
                        if (coll_inc && (coll_reg != '1))
                        begin
                            coll_reg <= coll_reg + 1'b1;
                        end
                        if (miss_inc && (miss_reg != '1))
                        begin
                            miss_reg <= miss_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = {6'b0, miss_reg, coll_reg, used_reg, fval_reg};

`ifndef SYNTHESIS
    // The read of a new request never meets a write in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> !ram_we)
        else $error("slot read issued together with a write");

    // An accepted request always reaches its compare cycle next
    a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (state_reg == ST_LOOK))
        else $error("accepted request did not enter compare cycle");

    // A request moves at most one counter
    a_one_counter: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({used_inc, coll_inc, miss_inc}))
        else $error("more than one counter moved for one request");

    // Counters never decrease
    a_counters_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((used_reg >= $past(used_reg)) && (coll_reg >= $past(coll_reg))
                  && (miss_reg >= $past(miss_reg))))
        else $error("counter decreased");

    // A hit response only follows a lookup
    a_hit_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && hit_next) |-> (op_reg == OP_LOOKUP) && !skip_reg)
        else $error("hit reported for a store or skipped request");
`endif

endmodule : direct_mapped_position_table

`default_nettype wire

// ===== tb/tb_direct_mapped_position_table.sv =====
`timescale 1ns / 1ps

module tb_direct_mapped_position_table;
    import dmpt_pkg::*;

    // Nothing is accepted for this many cycles: give up. Covers the clearing
    // pass after reset and the long receiver hold-off with plenty of room.
    localparam int unsigned WATCHDOG_CYCLES = 20000;
    // Hold m_tready low this long during the backpressure test
    localparam int unsigned HOLDOFF_CYCLES  = 300;
    // Cycles to let pass once every response is in
    localparam int unsigned SETTLE_CYCLES   = 4;
    // Keep this many recently stored positions around for lookups
    localparam int unsigned POSITION_POOL   = 48;
    // First register index that maps to nothing
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_UNMAPPED = 3'd5;
    // Receiver ready pattern, walked one bit per cycle
    localparam logic [15:0] READY_PATTERN = 16'b1101_0011_1000_1110;

    typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

    typedef struct {
        op_t                op;
        logic [HASH_W-1:0]  position_hash;
        logic [HASH_W-1:0]  mirror_hash;
        logic [MAP_W-1:0]   white_stones;
        logic [MAP_W-1:0]   black_stones;
        logic [TURN_W-1:0]  turn_number;
        logic [VALUE_W-1:0] store_value;
    } position_request_t;

    typedef struct {
        logic               hit;
        logic [VALUE_W-1:0] found_value;
        logic [COUNT_W-1:0] entries_used;
        logic [COUNT_W-1:0] collisions;
        logic [COUNT_W-1:0] misses;
    } table_response_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Shadow of the configuration registers, at their reset values
    logic              limit_turns       = 1'b0;
    logic [TURN_W-1:0] turn_ceiling      = 6'd63;
    logic              use_mirror        = 1'b1;
    logic              limit_mirror      = 1'b0;
    logic [TURN_W-1:0] mirror_turn_bound = 6'd63;

    // Shadow of the table and its counters
    bit                 slot_filled     [TABLE_ENTRIES];
    logic [MAP_W-1:0]   slot_white_map  [TABLE_ENTRIES];
    logic [MAP_W-1:0]   slot_black_map  [TABLE_ENTRIES];
    logic [VALUE_W-1:0] slot_result     [TABLE_ENTRIES];
    logic [COUNT_W-1:0] slots_filled_count = '0;
    logic [COUNT_W-1:0] overwrite_count    = '0;
    logic [COUNT_W-1:0] lookup_miss_count  = '0;

    table_response_t   expected_responses[$];
    position_request_t known_positions[$];
    int unsigned       failures = 0;

    // Sender burst shaping and receiver behavior, set per test
    int unsigned burst_left = 0;
    int unsigned gap_max    = 0;
    sink_mode_t  sink_mode  = SINK_OPEN;
    bit          holdoff_requested = 1'b0;

    direct_mapped_position_table dut (
        .clk,
        .rst_n,
        .s_tvalid,
        .s_tready,
        .s_tdata,
        .s_tuser,
        .m_tvalid,
        .m_tready,
        .m_tdata,
        .m_tuser,
        .cfg_we,
        .cfg_addr,
        .cfg_wdata
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    function automatic logic [COUNT_W-1:0] saturating_bump(input logic [COUNT_W-1:0] count);
        return (count == '1) ? count : count + 1'b1;
    endfunction

    // Advance the shadow table by one request and return the response it owes
    function automatic table_response_t predict_table_response(input position_request_t r);
        table_response_t   rsp;
        logic              bypass;
        logic              mirrored;
        logic [HASH_W-1:0] chosen;
        int unsigned       slot;

        rsp.hit         = 1'b0;
        rsp.found_value = (r.op == OP_STORE) ? r.store_value : '0;
        // Late turns leave the table and the counters alone
        bypass = limit_turns && (r.turn_number > turn_ceiling);
        if (!bypass)
        begin
            mirrored = use_mirror && (!limit_mirror || r.turn_number < mirror_turn_bound);
            chosen   = (mirrored && r.mirror_hash >= r.position_hash) ? r.mirror_hash
                                                                      : r.position_hash;
            slot     = int'(chosen % 64'(TABLE_ENTRIES));
            if (r.op == OP_LOOKUP)
            begin
                if (slot_filled[slot] && slot_white_map[slot] == r.white_stones &&
                    slot_black_map[slot] == r.black_stones)
                begin
                    rsp.hit         = 1'b1;
                    rsp.found_value = slot_result[slot];
                end
                else
                begin
                    lookup_miss_count = saturating_bump(lookup_miss_count);
                end
            end
            else
            begin
                // Always replace: an occupied slot counts as a collision
                if (slot_filled[slot])
                    overwrite_count = saturating_bump(overwrite_count);
                else
                    slots_filled_count = saturating_bump(slots_filled_count);
                slot_filled[slot]    = 1'b1;
                slot_white_map[slot] = r.white_stones;
                slot_black_map[slot] = r.black_stones;
                slot_result[slot]    = r.store_value;
            end
        end
        rsp.entries_used = slots_filled_count;
        rsp.collisions   = overwrite_count;
        rsp.misses       = lookup_miss_count;
        return rsp;
    endfunction

    //------------------------------------------------------------------
    // Configuration writes
    //------------------------------------------------------------------

    // Drive one register write and mirror it; cfg_we stays high for the caller
    task automatic write_register(input logic [CFG_ADDR_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            CFG_TURN_LIMIT_EN: limit_turns       = data[0];
            CFG_TURN_LIMIT:    turn_ceiling      = data[TURN_W-1:0];
            CFG_SYM_EN:        use_mirror        = data[0];
            CFG_SYM_LIMIT_EN:  limit_mirror      = data[0];
            CFG_SYM_TURN_LIM:  mirror_turn_bound = data[TURN_W-1:0];
            default: ;
        endcase
    endtask

    // Write all five registers; junk in the unused upper bits of the flags
    task automatic apply_settings(input logic te, input logic [TURN_W-1:0] tl,
                                  input logic se, input logic sle,
                                  input logic [TURN_W-1:0] stl);
        write_register(CFG_TURN_LIMIT_EN, {5'($urandom), te});
        write_register(CFG_TURN_LIMIT, tl);
        write_register(CFG_SYM_EN, {5'($urandom), se});
        write_register(CFG_SYM_LIMIT_EN, {5'($urandom), sle});
        write_register(CFG_SYM_TURN_LIM, stl);
        cfg_we <= 1'b0;
    endtask

    //------------------------------------------------------------------
    // Request side
    //------------------------------------------------------------------

    // Offer one request, predict its response once the block takes it.
    // Between bursts drop tvalid for a random gap; within a burst keep it high.
    task automatic send_request(input position_request_t r);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {r.store_value, r.turn_number, r.black_stones, r.white_stones,
                     r.mirror_hash, r.position_hash};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        expected_responses.push_back(predict_table_response(r));
    endtask

    // Drop tvalid and hold until every response is back
    task automatic wait_for_responses();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_responses.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic position_request_t make_request(
        input op_t op, input logic [HASH_W-1:0] h, input logic [HASH_W-1:0] mh,
        input logic [MAP_W-1:0] w, input logic [MAP_W-1:0] b,
        input logic [TURN_W-1:0] turn, input logic [VALUE_W-1:0] value);
        position_request_t r;
        r.op            = op;
        r.position_hash = h;
        r.mirror_hash   = mh;
        r.white_stones  = w;
        r.black_stones  = b;
        r.turn_number   = turn;
        r.store_value   = value;
        return r;
    endfunction

    function automatic logic [63:0] random_word();
        logic [63:0] w;
        case ($urandom_range(0, 15))
            0:       w = '0;
            1:       w = '1;
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    // Favor turns right around the configured limits
    function automatic logic [TURN_W-1:0] random_turn();
        logic [TURN_W-1:0] t;
        case ($urandom_range(0, 3))
            0:       t = turn_ceiling + TURN_W'($urandom_range(0, 2)) - 1'b1;
            1:       t = mirror_turn_bound + TURN_W'($urandom_range(0, 2)) - 1'b1;
            2:       t = $urandom_range(0, 1) ? '1 : '0;
            default: t = TURN_W'($urandom);
        endcase
        return t;
    endfunction

    // New position; a third of them crowd into a few slots to force collisions
    function automatic position_request_t fresh_position(input op_t op);
        position_request_t r;
        r = make_request(op, random_word(), random_word(), random_word(), random_word(),
                         random_turn(), VALUE_W'($urandom));
        if ($urandom_range(0, 15) == 0)
            r.mirror_hash = r.position_hash;
        if ($urandom_range(0, 2) == 0)
        begin
            r.position_hash[IDX_W-1:0] = IDX_W'($urandom_range(0, 31));
            r.mirror_hash[IDX_W-1:0]   = IDX_W'($urandom_range(0, 31));
        end
        return r;
    endfunction

    // Mostly new stores and stores and lookups of known positions, so hits and
    // overwrites are common; the rest look up corrupted or unknown positions.
    task automatic send_random_item();
        position_request_t r;
        int unsigned       kind;
        int unsigned       pick;
        int unsigned       bit_pos;
        kind = $urandom_range(0, 99);
        if (known_positions.size() == 0 || kind < 35)
        begin
            r = fresh_position(OP_STORE);
            known_positions.push_back(r);
            if (known_positions.size() > POSITION_POOL)
                known_positions.delete(0);
        end
        else if (kind >= 90)
        begin
            r = fresh_position(OP_LOOKUP);
        end
        else
        begin
            pick = $urandom_range(0, known_positions.size() - 1);
            r    = known_positions[pick];
            r.store_value = VALUE_W'($urandom);
            r.op          = (kind < 45) ? OP_STORE : OP_LOOKUP;
            if (kind >= 80)
            begin
                bit_pos = $urandom_range(0, MAP_W - 1);
                if ($urandom_range(0, 1))
                    r.white_stones[bit_pos] = ~r.white_stones[bit_pos];
                else
                    r.black_stones[bit_pos] = ~r.black_stones[bit_pos];
            end
            if ($urandom_range(0, 3) == 0)
                r.turn_number = random_turn();
        end
        send_request(r);
    endtask

    task automatic run_random_phase(input int unsigned items, input sink_mode_t mode,
                                    input int unsigned gaps);
        sink_mode  = mode;
        gap_max    = gaps;
        burst_left = 0;
        repeat (items) send_random_item();
        wait_for_responses();
    endtask

    //------------------------------------------------------------------
    // Response side
    //------------------------------------------------------------------

    // Stall on the selected pattern; on request hold off for a long stretch
    initial
    begin : response_sink
        int unsigned pattern_pos;
        pattern_pos = 0;
        forever
        begin
            @(posedge clk);
            if (holdoff_requested)
            begin
                holdoff_requested = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            pattern_pos = (pattern_pos + 1) % 16;
            case (sink_mode)
                SINK_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
                SINK_PATTERN: m_tready <= READY_PATTERN[pattern_pos];
                default:      m_tready <= 1'b1;
            endcase
        end
    end

    task automatic check_field(input string field, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            failures++;
        end
    endtask

    // Compare every accepted response with the oldest prediction
    always @(posedge clk)
    begin : response_check
        table_response_t want;
        if (m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (expected_responses.size() == 0)
            begin
                $error("response with no request outstanding");
                failures++;
            end
            else
            begin
                want = expected_responses.pop_front();
                check_field("hit", want.hit, m_tuser);
                check_field("found_value", want.found_value, m_tdata[1:0]);
                check_field("entries_used", want.entries_used, m_tdata[33:2]);
                check_field("collisions", want.collisions, m_tdata[65:34]);
                check_field("misses", want.misses, m_tdata[97:66]);
            end
        end
    end

    // End the run if neither side moves a request for too long
    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < WATCHDOG_CYCLES)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Empty-slot miss, extreme positions, symmetric indexing, overwrite
    task automatic test_basic_lookups_and_stores();
        position_request_t p;
        apply_settings(1'b0, 6'd63, 1'b1, 1'b0, 6'd63);
        sink_mode = SINK_OPEN;
        gap_max   = 0;
        // All-zero position, equal plain and mirrored hash: miss, store, hit
        send_request(make_request(OP_LOOKUP, '0, '0, '0, '0, 6'd0, 2'd3));
        send_request(make_request(OP_STORE, '0, '0, '0, '0, 6'd0, 2'd0));
        send_request(make_request(OP_LOOKUP, '0, '0, '0, '0, 6'd0, 2'd1));
        // All-ones position at the last turn
        send_request(make_request(OP_STORE, '1, '1, '1, '1, 6'd63, 2'd3));
        send_request(make_request(OP_LOOKUP, '1, '1, '1, '1, 6'd63, 2'd0));
        // Mirrored hash is larger, so it picks the slot; swapped hashes land there too
        p = make_request(OP_STORE, 64'h0000_0000_0000_0123, 64'hffff_0000_0000_0abc,
                         64'haaaa_5555_aaaa_5555, 64'h5555_aaaa_5555_aaaa, 6'd7, 2'd2);
        send_request(p);
        send_request(make_request(OP_LOOKUP, p.mirror_hash, p.position_hash,
                                  p.white_stones, p.black_stones, 6'd7, 2'd0));
        // Different position in the same slot replaces the first one
        send_request(make_request(OP_STORE, 64'h0000_0000_0001_0abc, '0,
                                  64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                                  6'd9, 2'd1));
        p.op = OP_LOOKUP;
        send_request(p);
        send_request(make_request(OP_LOOKUP, 64'h0000_0000_0001_0abc, '0,
                                  64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                                  6'd9, 2'd0));
        // One stone map matching is not enough
        send_request(make_request(OP_LOOKUP, 64'h0000_0000_0001_0abc, '0,
                                  64'h0123_4567_89ab_cdef, 64'h7edc_ba98_7654_3210,
                                  6'd9, 2'd0));
        send_request(make_request(OP_LOOKUP, 64'h0000_0000_0001_0abc, '0,
                                  64'h0123_4567_89ab_cdee, 64'hfedc_ba98_7654_3210,
                                  6'd9, 2'd0));
        // Same position stored again still counts as a collision
        send_request(make_request(OP_STORE, '1, '1, '1, '1, 6'd63, 2'd1));
        wait_for_responses();
    endtask

    // Turns past the limit skip the table and leave the counters alone
    task automatic test_turn_limit_bypass();
        apply_settings(1'b1, 6'd10, 1'b1, 1'b0, 6'd63);
        send_request(make_request(OP_STORE, 64'h055, '0, 64'h1, 64'h2, 6'd11, 2'd2));
        send_request(make_request(OP_LOOKUP, 64'h055, '0, 64'h1, 64'h2, 6'd11, 2'd3));
        send_request(make_request(OP_STORE, 64'h055, '0, 64'h1, 64'h2, 6'd10, 2'd2));
        send_request(make_request(OP_LOOKUP, 64'h055, '0, 64'h1, 64'h2, 6'd11, 2'd0));
        send_request(make_request(OP_LOOKUP, 64'h055, '0, 64'h1, 64'h2, 6'd10, 2'd0));
        wait_for_responses();
    endtask

    // Symmetry applies only below the symmetry turn limit
    task automatic test_symmetry_turn_limit();
        apply_settings(1'b0, 6'd63, 1'b1, 1'b1, 6'd5);
        send_request(make_request(OP_STORE, 64'h011, 64'h8000_0000_0000_0022,
                                  64'h4, 64'h8, 6'd4, 2'd3));
        send_request(make_request(OP_LOOKUP, 64'h011, 64'h8000_0000_0000_0022,
                                  64'h4, 64'h8, 6'd5, 2'd0));
        send_request(make_request(OP_LOOKUP, 64'h011, 64'h8000_0000_0000_0022,
                                  64'h4, 64'h8, 6'd4, 2'd0));
        wait_for_responses();
    endtask

    // Writes past the last register must change nothing
    task automatic test_unmapped_registers();
        for (int a = CFG_FIRST_UNMAPPED; a < 2 ** CFG_ADDR_W; a++)
            write_register(CFG_ADDR_W'(a), CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        run_random_phase(40, SINK_RANDOM, 3);
    endtask

    // Receiver holds off while requests keep coming: the block must stall
    // its input and lose nothing
    task automatic test_input_stall_under_backpressure();
        apply_settings(1'b0, 6'd63, 1'b1, 1'b0, 6'd63);
        sink_mode  = SINK_OPEN;
        gap_max    = 0;
        burst_left = 0;
        holdoff_requested = 1'b1;
        repeat (24) send_random_item();
        wait_for_responses();
    endtask

    // Random traffic across settings, extremes of both turn limits included
    task automatic test_random_traffic();
        apply_settings(1'b0, 6'd63, 1'b1, 1'b0, 6'd63);
        run_random_phase(150, SINK_RANDOM, 4);
        apply_settings(1'b0, 6'd63, 1'b0, 1'b0, 6'd63);
        run_random_phase(100, SINK_PATTERN, 0);
        apply_settings(1'b0, 6'd63, 1'b1, 1'b1, 6'd32);
        run_random_phase(90, SINK_OPEN, 6);
        apply_settings(1'b1, 6'd40, 1'b1, 1'b0, 6'd63);
        run_random_phase(100, SINK_RANDOM, 2);
        apply_settings(1'b1, 6'd0, 1'b1, 1'b1, 6'd0);
        run_random_phase(60, SINK_PATTERN, 3);
        apply_settings(1'b1, 6'd63, 1'b1, 1'b1, 6'd63);
        run_random_phase(100, SINK_RANDOM, 1);
        apply_settings(1'b1, 6'd31, 1'b0, 1'b1, 6'd1);
        run_random_phase(60, SINK_OPEN, 0);
    endtask

    initial
    begin
        // Reset once; registers are taken during the clearing pass that follows
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_lookups_and_stores();
        test_turn_limit_bypass();
        test_symmetry_turn_limit();
        test_unmapped_registers();
        test_input_stall_under_backpressure();
        test_random_traffic();
        wait_for_responses();
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
